// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the checksum core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/wxdc_pkg.sv =====
// Package with the types and constants of the word XOR-difference checksum core.
`default_nettype none

package wxdc_pkg;

   localparam int POS_W = 10;
   localparam int RSP_PAD_W = 7;

   localparam logic [POS_W-1:0] POS_ID        = 10'd0;
   localparam logic [POS_W-1:0] POS_LEN       = 10'd1;
   localparam logic [POS_W-1:0] POS_CKS_LO    = 10'd2;
   localparam logic [POS_W-1:0] POS_CKS_HI    = 10'd3;
   localparam logic [POS_W-1:0] POS_DEV       = 10'd7;
   localparam logic [POS_W-1:0] POS_DATA      = 10'd8;
   localparam logic [POS_W-1:0] MIN_MSG_BYTES = 10'd8;
   localparam logic [1:0]       LAST_LANE     = 2'd3;
   localparam logic [15:0]      CKS_INVERT    = 16'hFFFF;

   typedef struct packed {
      logic       sop;
      logic [7:0] msg_byte;
   } item_type;

   typedef struct packed {
      logic        checksum_ok;
      logic [15:0] checksum_value;
      logic [7:0]  message_id;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/wxdc_in_stage.sv =====
// Input register stage that holds one accepted item for the checksum core.
`default_nettype none

module wxdc_in_stage
   import wxdc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   input  wire logic     advance,
   output logic          out_valid,
   output item_type      out_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready  = !valid_ff || advance;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wxdc_core.sv =====
// Message tracking and checksum arithmetic for one item per cycle while advance is high.
`default_nettype none

module wxdc_core
   import wxdc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     insert_mode,
   input  wire logic     item_valid,
   input  wire item_type item,
   input  wire logic     advance,
   output logic          emit,
   output result_type    result
);

   logic             active_ff;
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       id_ff;
   logic [7:0]       len_ff;
   logic [15:0]      stored_ff;
   logic [15:0]      sum_ff;
   logic [23:0]      part_ff;

   logic             step_active;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] len_bytes;
   logic [POS_W-1:0] msg_bytes;
   logic             word_done;
   logic [15:0]      diff;
   logic [15:0]      sum_in;
   logic [15:0]      fin;
   logic             msg_end;

   always_comb begin
      step_active = item.sop || active_ff;
      pos         = item.sop ? POS_ID : pos_ff;
      pos_in      = pos + 10'd1;
      len_bytes   = {len_ff, 2'b00};
      msg_bytes   = (len_bytes < MIN_MSG_BYTES) ? MIN_MSG_BYTES : len_bytes;
      word_done   = (pos >= POS_DATA) && (pos[1:0] == LAST_LANE);
      diff        = {item.msg_byte, part_ff[23:16]} ^ part_ff[15:0];
      if (pos == POS_DEV) begin
         sum_in = {item.msg_byte, 8'h00};
      end else if (word_done) begin
         sum_in = sum_ff - diff;
      end else begin
         sum_in = sum_ff;
      end
      fin     = sum_in ^ CKS_INVERT;
      msg_end = pos_in >= msg_bytes;
      emit    = item_valid && step_active && msg_end;
      result.message_id     = id_ff;
      result.checksum_value = fin;
      result.checksum_ok    = insert_mode || (stored_ff == fin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else if (advance && step_active) begin
         active_ff <= !msg_end;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_active) begin
         sum_ff <= sum_in;
         if (pos == POS_ID) begin
            id_ff <= item.msg_byte;
         end
         if (pos == POS_LEN) begin
            len_ff <= item.msg_byte;
         end
         if (pos == POS_CKS_LO) begin
            stored_ff[7:0] <= item.msg_byte;
         end
         if (pos == POS_CKS_HI) begin
            stored_ff[15:8] <= item.msg_byte;
         end
         if (pos >= POS_DATA) begin
            case (pos[1:0])
               2'd0: begin
                  part_ff[7:0] <= item.msg_byte;
               end
               2'd1: begin
                  part_ff[15:8] <= item.msg_byte;
               end
               2'd2: begin
                  part_ff[23:16] <= item.msg_byte;
               end
               default: begin
                  part_ff <= part_ff;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/word_xor_difference_checksum_core.sv =====
// Top level of the word XOR-difference checksum core with its result register.
//
//   Channel   Direction  tdata (low bit up)                                 tuser
//   req_      in         msg_byte[7:0]                                      start_of_message
//   rsp_      out        message_id[7:0], checksum_value[23:8], ok[24], 0    -
//   csr_      in         insert_mode                                        -
//
// One byte is taken every cycle unless stalled; a result is registered after the input stage.
// The input register and the result register each hold one item, so bytes keep flowing
// while a finished result waits to be taken.
// The core stalls only when a byte that ends a message finds the result register full.
// Synchronous reset drops any open message and empties both registers.
`default_nettype none

module word_xor_difference_checksum_core
   import wxdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // msg_byte[7:0]
   input  wire logic        req_tuser,   // start_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // message_id[7:0], checksum_value[23:8],
                                         // checksum_ok[24], zero[31:25]
   input  wire logic        csr_we,
   input  wire logic        csr_wdata    // insert_mode
);

   logic       insert_mode_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;

   item_type   req_item;
   item_type   s1_item;
   logic       s1_valid;
   logic       advance;
   logic       emit;
   result_type result;

   assign req_item.sop      = req_tuser;
   assign req_item.msg_byte = req_tdata;

   wxdc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .advance   (advance),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   wxdc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .insert_mode (insert_mode_ff),
      .item_valid  (s1_valid),
      .item        (s1_item),
      .advance     (advance),
      .emit        (emit),
      .result      (result)
   );

   assign advance = s1_valid && (!emit || !rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_mode_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            insert_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff};

endmodule

`default_nettype wire

// ===== sv/wxdc_checker.sv =====
// Port-level assertion checker for the checksum core and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module wxdc_checker
   import wxdc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "result item dropped")
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata), "result changed")
   `ASSERT_CLK_RST(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[31:25] == '0, "pad not zero")
   `ASSERT_CLK(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind word_xor_difference_checksum_core wxdc_checker u_wxdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
